// ===== rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the motor stall detector
// Item structs for both channels, configuration and per-motor status.
// ----------------------------------------------------------------------------
package msd_pkg;

	// input item: one control tick
	typedef struct packed {
		logic [3:0] throttle_active_mask;
		logic [3:0] rpm_seen_mask;
		logic       other_disable;
	} msd_item_t;

	// result item
	typedef struct packed {
		logic       motors_blocked;
		logic       stall_detected;
		logic [3:0] unlocked_mask;
		logic       force_zero_throttle;
	} msd_result_t;

	// configuration register contents
	typedef struct packed {
		logic        stall_detect_enable;
		logic [13:0] stall_limit;
	} msd_cfg_t;

	// per-motor status toward the flag logic
	typedef struct packed {
		logic unlocked;
		logic saturated;
	} msd_cell_status_t;

	localparam int unsigned MASK_W      = 4;
	localparam int unsigned LIMIT_W     = 14;
	localparam int unsigned COUNTER_W   = 16;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	// register index, taken from paddr[2]
	localparam logic REG_STALL_DETECT_ENABLE = 1'b0;
	localparam logic REG_STALL_LIMIT         = 1'b1;

	localparam logic [LIMIT_W-1:0]   STALL_LIMIT_RESET = 14'd1600;
	localparam logic                 DETECT_EN_RESET   = 1'b1;
	localparam logic [COUNTER_W-1:0] STALL_STEP        = 16'd5;

endpackage

// ===== rtl/msd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// msd_apb_regs: configuration registers
// APB-style write/read of the enable bit and the stall limit.
// ----------------------------------------------------------------------------
module msd_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [msd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [msd_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output msd_pkg::msd_cfg_t             cfg
);
	import msd_pkg::*;

	logic     wr_en;
	msd_cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes; paddr[2] selects the register, the low address bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_detect_enable <= DETECT_EN_RESET;
			cfg_q.stall_limit         <= STALL_LIMIT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_STALL_DETECT_ENABLE: cfg_q.stall_detect_enable <= pwdata[0];
				REG_STALL_LIMIT:         cfg_q.stall_limit <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[2])
			REG_STALL_DETECT_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}},
				cfg_q.stall_detect_enable};
			REG_STALL_LIMIT:         prdata = {{(APB_DATA_W-LIMIT_W){1'b0}},
				cfg_q.stall_limit};
			default:                 prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/msd_motor_cell.sv =====
// ----------------------------------------------------------------------------
// msd_motor_cell: stall counter of one motor
// Holds the signed counter and computes its update for one tick.
// ----------------------------------------------------------------------------
module msd_motor_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        update,
	input  logic                        driven,
	input  logic                        spinning,
	input  logic                        other_disable,
	input  logic [msd_pkg::LIMIT_W-1:0] stall_limit,
	output msd_pkg::msd_cell_status_t   status
);
	import msd_pkg::*;

	logic signed [COUNTER_W-1:0] count_q;
	logic signed [COUNTER_W-1:0] count_next;
	logic signed [COUNTER_W-1:0] lim_s;
	logic signed [COUNTER_W-1:0] sum;

	assign lim_s = signed'({{(COUNTER_W-LIMIT_W){1'b0}}, stall_limit});
	assign sum   = count_q + signed'(STALL_STEP);

	// counter update rules
	always_comb begin
		count_next       = count_q;
		status.unlocked  = 1'b0;
		status.saturated = 1'b0;
		if (!driven || other_disable) begin
			count_next      = -lim_s;
			status.unlocked = 1'b1;
		end else if (!spinning) begin
			if (sum >= lim_s) begin
				count_next       = lim_s;
				status.saturated = 1'b1;
			end else begin
				count_next = sum;
			end
		end else if (count_q <= 0) begin
			status.unlocked = 1'b1;
			if (count_q < 0)
				count_next = count_q + 16'sd1;
		end else begin
			count_next = count_q - 16'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (update) begin
			count_q <= count_next;
		end
	end

endmodule

// ===== rtl/motor_stall_detector.sv =====
// ----------------------------------------------------------------------------
// motor_stall_detector: stall watch over a set of motors
// Input register, per-motor counter cells, blocked flag and result register.
// ----------------------------------------------------------------------------
// Items pass the input register, then the result register. All motor counters
// update in parallel; throughput: one item per cycle unless the result stalls.
// Reset: counters 0, blocked flag clear, detection enabled, limit 1600,
// both pipeline stages empty.
module motor_stall_detector #(
	parameter int unsigned MOTOR_COUNT = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [msd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [msd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [msd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  msd_pkg::msd_item_t             item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output msd_pkg::msd_result_t           result
);
	import msd_pkg::*;

	localparam int unsigned EXT_W = (MOTOR_COUNT > MASK_W) ? MOTOR_COUNT : MASK_W;

	msd_cfg_t         cfg;
	msd_item_t        item_s1;
	logic             valid_s1;
	logic             advance;
	msd_result_t      result_q;
	logic             result_valid_q;
	logic             blocked_q;
	logic             blocked_next;
	logic             detected;
	logic             any_sat;
	logic             all_unlocked;
	msd_cell_status_t cell_status [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] unlock;
	logic [MOTOR_COUNT-1:0] sat;
	logic [EXT_W-1:0]       unlock_ext;

	msd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: stage 1 moves when the result register is free or drains
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	// motor cells; motors past the mask width never see throttle
	for (genvar i = 0; i < MOTOR_COUNT; i++) begin : g_motor
		logic drv;
		logic spin;
		if (i < MASK_W) begin : g_in
			assign drv  = item_s1.throttle_active_mask[i];
			assign spin = item_s1.rpm_seen_mask[i];
		end else begin : g_out
			assign drv  = 1'b0;
			assign spin = 1'b0;
		end
		msd_motor_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.update        (advance),
			.driven        (drv),
			.spinning      (spin),
			.other_disable (item_s1.other_disable),
			.stall_limit   (cfg.stall_limit),
			.status        (cell_status[i])
		);
		assign unlock[i] = cell_status[i].unlocked;
		assign sat[i]    = cell_status[i].saturated;
	end

	// blocked flag
	assign any_sat      = |sat;
	assign all_unlocked = &unlock;
	assign detected     = cfg.stall_detect_enable && !blocked_q && any_sat;
	assign blocked_next = (blocked_q || detected) && !all_unlocked;
	assign unlock_ext   = EXT_W'(unlock);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= 1'b0;
		end else if (advance) begin
			blocked_q <= blocked_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.motors_blocked      <= blocked_next;
			result_q.stall_detected      <= detected;
			result_q.unlocked_mask       <= unlock_ext[MASK_W-1:0];
			result_q.force_zero_throttle <= blocked_next || item_s1.other_disable;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	a_detect_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stall_detected |-> result.motors_blocked)
		else $error("stall reported without blocked flag");

	a_blocked_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.motors_blocked |-> result.force_zero_throttle)
		else $error("blocked flag without forced zero throttle");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("input stalled with empty stage");

	a_flag_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.motors_blocked == blocked_q)
		else $error("result flag differs from blocked state");

endmodule
